>>> hdl/spq_pkg.sv
`timescale 1ns / 1ps

package spq_pkg;

	localparam int VALUE_W  = 32;
	localparam int RANK_W   = 16;
	localparam int STATUS_W = 2;
	localparam int FILL_W   = 5;

	typedef enum logic {
		OP_ENQUEUE = 1'b0,
		OP_DEQUEUE = 1'b1
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_ENQUEUED = 2'd0,
		ST_DEQUEUED = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	// One stored entry as it travels along the chain.
	typedef struct packed {
		logic                      valid;
		logic signed [VALUE_W-1:0] value;
		logic [RANK_W-1:0]         rank;
	} entry_t;

	// Broadcast command to every cell.
	typedef struct packed {
		logic                      enq;
		logic                      deq;
		logic signed [VALUE_W-1:0] value;
		logic [RANK_W-1:0]         rank;
	} cell_cmd_t;

endpackage

>>> hdl/spq_if.sv
`timescale 1ns / 1ps

interface spq_req_if;
	logic                               valid;
	logic                               ready;
	spq_pkg::op_t                       opcode;
	logic signed [spq_pkg::VALUE_W-1:0] item_value;
	logic [spq_pkg::RANK_W-1:0]         item_rank;

	modport source (output valid, opcode, item_value, item_rank, input ready);
	modport sink   (input valid, opcode, item_value, item_rank, output ready);
endinterface

interface spq_rsp_if;
	logic                               valid;
	logic                               ready;
	spq_pkg::status_t                   status;
	logic signed [spq_pkg::VALUE_W-1:0] out_value;
	logic [spq_pkg::RANK_W-1:0]         out_rank;
	logic [spq_pkg::FILL_W-1:0]         fill;

	modport source (output valid, status, out_value, out_rank, fill, input ready);
	modport sink   (input valid, status, out_value, out_rank, fill, output ready);
endinterface

>>> hdl/spq_cell.sv
`timescale 1ns / 1ps

// One slot of the sorted chain. On enqueue it keeps its entry, takes the new
// one or takes its lower neighbour's; on dequeue it takes its upper neighbour's.
module spq_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  spq_pkg::cell_cmd_t cmd,
	input  spq_pkg::entry_t    prev_entry,
	input  logic               prev_le,
	input  spq_pkg::entry_t    next_entry,
	output spq_pkg::entry_t    entry,
	output logic               le
);

	logic                               valid_q;
	logic signed [spq_pkg::VALUE_W-1:0] value_q;
	logic [spq_pkg::RANK_W-1:0]         rank_q;
	spq_pkg::entry_t                    entry_d;

	// Entry ranks at or below the new rank stay in front of it.
	assign le = valid_q && (rank_q <= cmd.rank);

	always_comb begin
		entry_d.valid = valid_q;
		entry_d.value = value_q;
		entry_d.rank  = rank_q;
		if (cmd.enq) begin
			if (!le) begin
				if (prev_le) begin
					entry_d.valid = 1'b1;
					entry_d.value = cmd.value;
					entry_d.rank  = cmd.rank;
				end else begin
					entry_d = prev_entry;
				end
			end
		end else if (cmd.deq) begin
			entry_d = next_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= entry_d.valid;
		end
	end

	always_ff @(posedge clk) begin
		value_q <= entry_d.value;
		rank_q  <= entry_d.rank;
	end

	assign entry.valid = valid_q;
	assign entry.value = value_q;
	assign entry.rank  = rank_q;

endmodule

>>> hdl/sorted_priority_queue_core.sv
`timescale 1ns / 1ps

// Sorted priority queue, CAPACITY entries held in a chain of compare/shift cells.
// req channel: one transaction per command. opcode enqueue stores item_value
//   with item_rank; opcode dequeue removes the front entry (lowest rank,
//   oldest first among equal ranks).
// rsp channel: exactly one transaction per request, in request order, with
//   status (enqueued, dequeued, empty, full), the removed entry on a dequeue
//   (zero otherwise) and fill, the entry count after the command.
// Latency: the response is valid the cycle after the request is accepted.
// Throughput: one request per cycle unless rsp stalls. Every cell compares its
//   rank with the new and shifts in the same cycle; no command waits on another.
// Stall: the response sits in an output register; req.ready stays high while
//   that register is empty or being drained, so a stalled receiver holds
//   back new requests, with at most one response pending.
// Reset (arst_n low): all cells empty, entry count zero, no response pending.
// Enqueue into a full queue and dequeue from an empty one leave the contents
// untouched and only report the status.
module sorted_priority_queue_core #(
	parameter int CAPACITY = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	spq_req_if.sink  req,
	spq_rsp_if.source rsp
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	spq_pkg::entry_t    cell_entry [CAPACITY];
	logic               cell_le    [CAPACITY];
	spq_pkg::cell_cmd_t cmd;
	spq_pkg::entry_t    empty_entry;

	logic             accept;
	logic             full;
	logic             empty;
	logic [CNT_W-1:0] occ_q;
	logic [CNT_W-1:0] occ_d;
	logic [CNT_W+spq_pkg::FILL_W-1:0] occ_wide;

	logic                               rsp_valid_q;
	spq_pkg::status_t                   status_q;
	spq_pkg::status_t                   status_d;
	logic signed [spq_pkg::VALUE_W-1:0] out_value_q;
	logic signed [spq_pkg::VALUE_W-1:0] out_value_d;
	logic [spq_pkg::RANK_W-1:0]         out_rank_q;
	logic [spq_pkg::RANK_W-1:0]         out_rank_d;
	logic [spq_pkg::FILL_W-1:0]         fill_q;

	// Output register frees up when empty or being taken this cycle.
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	assign full  = cell_entry[CAPACITY-1].valid;
	assign empty = !cell_entry[0].valid;

	assign empty_entry = '0;

	always_comb begin
		cmd.enq   = accept && (req.opcode == spq_pkg::OP_ENQUEUE) && !full;
		cmd.deq   = accept && (req.opcode == spq_pkg::OP_DEQUEUE) && !empty;
		cmd.value = req.item_value;
		cmd.rank  = req.item_rank;
	end

	// Chain: cell 0 is the front. The new entry enters where the "at or below"
	// run of ranks ends; cells above it take their lower neighbour.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		if (i == 0) begin : g_first
			spq_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.cmd       (cmd),
				.prev_entry(empty_entry),
				.prev_le   (1'b1),
				.next_entry(cell_entry[i+1]),
				.entry     (cell_entry[i]),
				.le        (cell_le[i])
			);
		end else if (i == CAPACITY - 1) begin : g_last
			spq_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.cmd       (cmd),
				.prev_entry(cell_entry[i-1]),
				.prev_le   (cell_le[i-1]),
				.next_entry(empty_entry),
				.entry     (cell_entry[i]),
				.le        (cell_le[i])
			);
		end else begin : g_mid
			spq_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.cmd       (cmd),
				.prev_entry(cell_entry[i-1]),
				.prev_le   (cell_le[i-1]),
				.next_entry(cell_entry[i+1]),
				.entry     (cell_entry[i]),
				.le        (cell_le[i])
			);
		end
	end

	// Entry count and response fields for the accepted request.
	always_comb begin
		occ_d       = occ_q;
		out_value_d = '0;
		out_rank_d  = '0;
		if (req.opcode == spq_pkg::OP_ENQUEUE) begin
			if (full) begin
				status_d = spq_pkg::ST_FULL;
			end else begin
				status_d = spq_pkg::ST_ENQUEUED;
				occ_d    = occ_q + CNT_W'(1);
			end
		end else begin
			if (empty) begin
				status_d = spq_pkg::ST_EMPTY;
			end else begin
				status_d    = spq_pkg::ST_DEQUEUED;
				occ_d       = occ_q - CNT_W'(1);
				out_value_d = cell_entry[0].value;
				out_rank_d  = cell_entry[0].rank;
			end
		end
	end

	// fill carries the low bits of the count.
	assign occ_wide = (CNT_W + spq_pkg::FILL_W)'(occ_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				occ_q       <= occ_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q    <= status_d;
			out_value_q <= out_value_d;
			out_rank_q  <= out_rank_d;
			fill_q      <= occ_wide[spq_pkg::FILL_W-1:0];
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.status    = status_q;
	assign rsp.out_value = out_value_q;
	assign rsp.out_rank  = out_rank_q;
	assign rsp.fill      = fill_q;

endmodule

>>> hdl/spq_checker.sv
`timescale 1ns / 1ps

module spq_checker #(
	parameter int CAPACITY = 16
) (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               req_valid,
	input logic                               req_ready,
	input logic                               rsp_valid,
	input logic                               rsp_ready,
	input spq_pkg::status_t                   status,
	input logic signed [spq_pkg::VALUE_W-1:0] out_value,
	input logic [spq_pkg::RANK_W-1:0]         out_rank,
	input logic [spq_pkg::FILL_W-1:0]         fill
);

	// Every accepted request has its response the next cycle.
	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> rsp_valid)
		else $error("no response after accepted request");

	// Empty report carries nothing.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && status == spq_pkg::ST_EMPTY) |->
		(out_value == '0 && out_rank == '0 && fill == '0))
		else $error("empty response with payload");

	// A full report means the count is at capacity.
	a_full_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && status == spq_pkg::ST_FULL) |->
		(fill == spq_pkg::FILL_W'(CAPACITY)))
		else $error("full response below capacity");

	// Stalled response holds.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=>
		(rsp_valid && $stable(status) && $stable(out_value) && $stable(out_rank)
			&& $stable(fill)))
		else $error("stalled response changed");

endmodule

bind sorted_priority_queue_core spq_checker #(
	.CAPACITY(CAPACITY)
) u_spq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.status   (rsp.status),
	.out_value(rsp.out_value),
	.out_rank (rsp.out_rank),
	.fill     (rsp.fill)
);
